@@ rtl/dap_pkg.sv @@
// Shared widths, constants and types of the dihedral angle pipeline.
package dap_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CRD_N = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  localparam int CW   = 24;          // coordinate
  localparam int DW   = 25;          // edge vector component
  localparam int PW   = 50;          // 25x25 product
  localparam int QW   = 51;          // cross product component, signed
  localparam int QMW  = 50;          // cross product magnitude
  localparam int HW   = 25;          // half of a cross product magnitude
  localparam int CMW  = 24;          // |cd| component
  localparam int PPW  = 2 * HW;      // partial product for Q.T
  localparam int VPPW = HW + CMW;    // partial product for Q.CD
  localparam int QTP  = 100;         // |q_i * t_i|
  localparam int VP   = 74;          // |q_i * cd_i|
  localparam int VW   = 78;          // V = Q.CD, two's complement
  localparam int XW   = 104;         // Q.T, two's complement
  localparam int VMW  = VW - 1;
  localparam int XMW  = XW - 1;
  localparam int BBW  = 50;          // BC.BC
  localparam int SW   = 31;          // |BC| with 6 extra fraction bits
  localparam int SQ_ST = 16;         // square root stages, two result bits each
  localparam int YCW  = 26;          // chunk of |V| per partial product
  localparam int YPW  = YCW + SW;
  localparam int NW   = 128;         // normalizer word
  localparam int AW   = 30;          // CORDIC start vector bits
  localparam int ZW   = 34;          // CORDIC datapath
  localparam int OW   = 16;          // angle output

  localparam int S_SQ_IN = 3;                  // stage whose BC.BC feeds the root
  localparam int DLY     = S_SQ_IN + SQ_ST - 8; // delay of |V|, |Q.T| to meet the root
  localparam int LAT     = 26 + CRD_N;          // input to output register

  localparam int PI_Q13      = 25736;
  localparam int RND_Q30     = 65536;
  localparam int RND_SH      = 17;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  localparam logic [30:0] ATAN_Q30 [32] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1, 31'd0, 31'd0
  };

  typedef struct packed {
    logic vneg;
    logic xneg;
    logic yzero;
    logic xzero;
  } dap_tag_t;

endpackage

@@ rtl/dap_if.sv @@
// Point and result channel interfaces.
interface dap_pts_if;
  import dap_pkg::*;
  logic valid;
  logic ready;
  logic signed [CW-1:0] a_x, a_y, a_z;
  logic signed [CW-1:0] b_x, b_y, b_z;
  logic signed [CW-1:0] c_x, c_y, c_z;
  logic signed [CW-1:0] d_x, d_y, d_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  d_x, d_y, d_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                d_x, d_y, d_z, output ready);
endinterface

interface dap_res_if;
  import dap_pkg::*;
  logic valid;
  logic ready;
  logic signed [OW-1:0] angle;
  logic degenerate;
  modport source (output valid, angle, degenerate, input ready);
  modport sink (input valid, angle, degenerate, output ready);
endinterface

@@ rtl/dap_isqrt.sv @@
// Pipelined integer square root of BC.BC * 4096, two result bits per stage.
module dap_isqrt (
  input  logic                   clk,
  input  logic                   en,
  input  logic [dap_pkg::BBW-1:0] bb,
  output logic [dap_pkg::SW-1:0]  s
);
  import dap_pkg::*;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  function automatic sq_t sq_step(input sq_t a, input logic [63:0] b);
    sq_t o;
    o = a;
    if (a.n >= a.r + b) begin
      o.n = a.n - (a.r + b);
      o.r = (a.r >> 1) + b;
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  sq_t st [SQ_ST];
  sq_t st_next [SQ_ST];

  always_comb begin
    sq_t cur;
    for (int g = 0; g < SQ_ST; g++) begin
      if (g == 0) begin
        cur.n = {2'b0, bb, 12'b0};
        cur.r = '0;
      end else begin
        cur = st[g-1];
      end
      cur = sq_step(cur, 64'd1 << (2 * (2 * SQ_ST - 1) - 4 * g));
      st_next[g] = sq_step(cur, 64'd1 << (2 * (2 * SQ_ST - 1) - 4 * g - 2));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < SQ_ST; g++) st[g] <= st_next[g];
    end
  end

  assign s = st[SQ_ST-1].r[SW-1:0];

endmodule

@@ rtl/dap_cordic.sv @@
// Vectoring CORDIC, one micro-rotation per pipeline stage.
module dap_cordic (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [dap_pkg::ZW-1:0] x_in,
  input  logic signed [dap_pkg::ZW-1:0] y_in,
  input  logic signed [dap_pkg::ZW-1:0] z_in,
  input  dap_pkg::dap_tag_t             tag_in,
  output logic signed [dap_pkg::ZW-1:0] z_out,
  output dap_pkg::dap_tag_t             tag_out
);
  import dap_pkg::*;

  logic signed [ZW-1:0] x_q [CRD_N];
  logic signed [ZW-1:0] y_q [CRD_N];
  logic signed [ZW-1:0] z_q [CRD_N];
  dap_tag_t             t_q [CRD_N];
  logic signed [ZW-1:0] x_next [CRD_N];
  logic signed [ZW-1:0] y_next [CRD_N];
  logic signed [ZW-1:0] z_next [CRD_N];

  always_comb begin
    logic signed [ZW-1:0] xp, yp, zp, dx, dy, at;
    for (int i = 0; i < CRD_N; i++) begin
      if (i == 0) begin
        xp = x_in; yp = y_in; zp = z_in;
      end else begin
        xp = x_q[i-1]; yp = y_q[i-1]; zp = z_q[i-1];
      end
      dx = yp >>> i;
      dy = xp >>> i;
      at = ZW'(ATAN_Q30[i[4:0]]);
      if (!yp[ZW-1]) begin
        x_next[i] = xp + dx; y_next[i] = yp - dy; z_next[i] = zp + at;
      end else begin
        x_next[i] = xp - dx; y_next[i] = yp + dy; z_next[i] = zp - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CRD_N; i++) begin
        x_q[i] <= x_next[i];
        y_q[i] <= y_next[i];
        z_q[i] <= z_next[i];
        t_q[i] <= (i == 0) ? tag_in : t_q[i-1];
      end
    end
  end

  assign z_out   = z_q[CRD_N-1];
  assign tag_out = t_q[CRD_N-1];

endmodule

@@ rtl/dihedral_angle_four_points_core.sv @@
// Throughput: one transaction per cycle while no result is held; the longest chain is
// the 2-bit-per-stage square root, with Q.T and Q.CD delayed to meet it, then a
// one-step-per-stage CORDIC.
// A held result stalls every stage together; ready is low only while it waits.
// Synchronous reset clears the valid bits; data registers are not reset.
module dihedral_angle_four_points_core (
  input  logic      clk,
  input  logic      rst,
  dap_pts_if.sink   pts,
  dap_res_if.source res
);
  import dap_pkg::*;

  typedef struct packed {
    logic [NW-1:0] y;
    logic [NW-1:0] x;
  } yx_t;

  function automatic yx_t nstep(input yx_t a, input int k);
    yx_t r;
    r = a;
    if (((a.y | a.x) >> (NW - k)) == '0) begin
      r.y = a.y << k;
      r.x = a.x << k;
    end
    return r;
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !vld[LAT-1] || res.ready;
  assign pts.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pts.valid};
    end
  end

  // stage 1: edge vectors
  logic signed [DW-1:0] ab1 [3], bc1 [3], cd1 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      ab1[0] <= DW'(pts.b_x) - DW'(pts.a_x);
      ab1[1] <= DW'(pts.b_y) - DW'(pts.a_y);
      ab1[2] <= DW'(pts.b_z) - DW'(pts.a_z);
      bc1[0] <= DW'(pts.c_x) - DW'(pts.b_x);
      bc1[1] <= DW'(pts.c_y) - DW'(pts.b_y);
      bc1[2] <= DW'(pts.c_z) - DW'(pts.b_z);
      cd1[0] <= DW'(pts.d_x) - DW'(pts.c_x);
      cd1[1] <= DW'(pts.d_y) - DW'(pts.c_y);
      cd1[2] <= DW'(pts.d_z) - DW'(pts.c_z);
    end
  end

  // stage 2: cross product terms and squares of BC
  logic signed [PW-1:0] pqa2 [3], pqb2 [3], pta2 [3], ptb2 [3], sq2 [3];
  logic signed [DW-1:0] cd2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pqa2[j] <= PW'(ab1[NXT1[j]]) * PW'(bc1[NXT2[j]]);
        pqb2[j] <= PW'(bc1[NXT1[j]]) * PW'(ab1[NXT2[j]]);
        pta2[j] <= PW'(bc1[NXT1[j]]) * PW'(cd1[NXT2[j]]);
        ptb2[j] <= PW'(cd1[NXT1[j]]) * PW'(bc1[NXT2[j]]);
        sq2[j]  <= PW'(bc1[j]) * PW'(bc1[j]);
        cd2[j]  <= cd1[j];
      end
    end
  end

  // stage 3: Q, T, BC.BC
  logic signed [QW-1:0] q3 [3], t3 [3];
  logic signed [DW-1:0] cd3 [3];
  logic [BBW-1:0]       bb3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        q3[j]  <= QW'(pqa2[j]) - QW'(pqb2[j]);
        t3[j]  <= QW'(pta2[j]) - QW'(ptb2[j]);
        cd3[j] <= cd2[j];
      end
      bb3 <= BBW'(sq2[0]) + BBW'(sq2[1]) + BBW'(sq2[2]);
    end
  end

  // stage 4: sign and magnitude
  logic [QMW-1:0] qm4 [3], tm4 [3];
  logic [CMW-1:0] cdm4 [3];
  logic [2:0]     sqt4, sqc4;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        qm4[j]  <= QMW'(q3[j][QW-1] ? -q3[j] : q3[j]);
        tm4[j]  <= QMW'(t3[j][QW-1] ? -t3[j] : t3[j]);
        cdm4[j] <= CMW'(cd3[j][DW-1] ? -cd3[j] : cd3[j]);
        sqt4[j] <= q3[j][QW-1] ^ t3[j][QW-1];
        sqc4[j] <= q3[j][QW-1] ^ cd3[j][DW-1];
      end
    end
  end

  // stage 5: partial products
  logic [PPW-1:0]  ll5 [3], lh5 [3], hl5 [3], hh5 [3];
  logic [VPPW-1:0] vl5 [3], vh5 [3];
  logic [2:0]      sqt5, sqc5;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ll5[j] <= PPW'(qm4[j][HW-1:0])   * PPW'(tm4[j][HW-1:0]);
        lh5[j] <= PPW'(qm4[j][HW-1:0])   * PPW'(tm4[j][QMW-1:HW]);
        hl5[j] <= PPW'(qm4[j][QMW-1:HW]) * PPW'(tm4[j][HW-1:0]);
        hh5[j] <= PPW'(qm4[j][QMW-1:HW]) * PPW'(tm4[j][QMW-1:HW]);
        vl5[j] <= VPPW'(qm4[j][HW-1:0])   * VPPW'(cdm4[j]);
        vh5[j] <= VPPW'(qm4[j][QMW-1:HW]) * VPPW'(cdm4[j]);
      end
      sqt5 <= sqt4;
      sqc5 <= sqc4;
    end
  end

  // stage 6: assemble the full products
  logic [QTP-1:0] pqt6 [3];
  logic [VP-1:0]  pv6 [3];
  logic [2:0]     sqt6, sqc6;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pqt6[j] <= (QTP'(hh5[j]) << (2 * HW)) +
                   ((QTP'(lh5[j]) + QTP'(hl5[j])) << HW) + QTP'(ll5[j]);
        pv6[j]  <= (VP'(vh5[j]) << HW) + VP'(vl5[j]);
      end
      sqt6 <= sqt5;
      sqc6 <= sqc5;
    end
  end

  // stage 7: signed dot products
  logic [VW-1:0] v7_next, v7;
  logic [XW-1:0] x7_next, x7;
  always_comb begin
    logic [VW-1:0] vt;
    logic [XW-1:0] xt;
    v7_next = '0;
    x7_next = '0;
    for (int j = 0; j < 3; j++) begin
      vt = VW'(pv6[j]);
      xt = XW'(pqt6[j]);
      v7_next = v7_next + (sqc6[j] ? -vt : vt);
      x7_next = x7_next + (sqt6[j] ? -xt : xt);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v7 <= v7_next;
      x7 <= x7_next;
    end
  end

  // stage 8: magnitudes
  logic [VMW-1:0] vm8;
  logic [XMW-1:0] xm8;
  dap_tag_t       tag8;
  always_ff @(posedge clk) begin
    if (en) begin
      vm8  <= VMW'(v7[VW-1] ? -v7 : v7);
      xm8  <= XMW'(x7[XW-1] ? -x7 : x7);
      tag8 <= '{vneg: v7[VW-1], xneg: x7[XW-1], yzero: 1'b0, xzero: 1'b0};
    end
  end

  // square root of BC.BC runs beside stages 4 onward
  logic [SW-1:0] s19;
  dap_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .bb  (bb3),
    .s   (s19)
  );

  // stages 9 .. 19: hold |V| and |Q.T| until the root is out
  logic [VMW-1:0] dvm [DLY];
  logic [XMW-1:0] dxm [DLY];
  dap_tag_t       dtag [DLY];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DLY; k++) begin
        dvm[k]  <= (k == 0) ? vm8  : dvm[k-1];
        dxm[k]  <= (k == 0) ? xm8  : dxm[k-1];
        dtag[k] <= (k == 0) ? tag8 : dtag[k-1];
      end
    end
  end

  // stage 20: |V| * s in three chunks, X = |Q.T| << 6
  logic [3*YCW-1:0] vpad;
  logic [YPW-1:0]   yp20 [3];
  logic [NW-1:0]    x20;
  dap_tag_t         tag20;
  assign vpad = (3 * YCW)'(dvm[DLY-1]);
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        yp20[k] <= YPW'(vpad[k*YCW +: YCW]) * YPW'(s19);
      end
      x20   <= NW'(dxm[DLY-1]) << 6;
      tag20 <= dtag[DLY-1];
    end
  end

  // stage 21: sum the chunks
  logic [NW-1:0] y21, x21;
  dap_tag_t      tag21;
  always_ff @(posedge clk) begin
    if (en) begin
      y21   <= NW'(yp20[0]) + (NW'(yp20[1]) << YCW) + (NW'(yp20[2]) << (2 * YCW));
      x21   <= x20;
      tag21 <= tag20;
    end
  end

  // stages 22 .. 24: normalize so the larger operand's top bit lands on bit NW-1
  yx_t      n22, n23, n24;
  dap_tag_t tag22, tag23, tag24;
  always_ff @(posedge clk) begin
    if (en) begin
      n22         <= nstep(nstep('{y: y21, x: x21}, 64), 32);
      tag22       <= '{vneg: tag21.vneg, xneg: tag21.xneg,
                       yzero: (y21 == '0), xzero: (x21 == '0)};
      n23         <= nstep(nstep(n22, 16), 8);
      tag23       <= tag22;
      n24         <= nstep(nstep(nstep(n23, 4), 2), 1);
      tag24       <= tag23;
    end
  end

  // stage 25: CORDIC start vector, pre-rotated by pi/2 for a negative cosine part
  logic signed [ZW-1:0] cx25, cy25, cz25;
  dap_tag_t             tag25;
  always_ff @(posedge clk) begin
    if (en) begin
      if (tag24.xneg) begin
        cx25 <= ZW'(n24.y[NW-1 -: AW]);
        cy25 <= ZW'(n24.x[NW-1 -: AW]);
        cz25 <= ZW'(HALF_PI_Q30);
      end else begin
        cx25 <= ZW'(n24.x[NW-1 -: AW]);
        cy25 <= ZW'(n24.y[NW-1 -: AW]);
        cz25 <= '0;
      end
      tag25 <= tag24;
    end
  end

  logic signed [ZW-1:0] zc;
  dap_tag_t             tagc;
  dap_cordic u_cordic (
    .clk     (clk),
    .en      (en),
    .x_in    (cx25),
    .y_in    (cy25),
    .z_in    (cz25),
    .tag_in  (tag25),
    .z_out   (zc),
    .tag_out (tagc)
  );

  // output stage: round Q30 to Q13, clamp, apply sign and special cases
  logic signed [ZW-1:0] za, zq;
  logic signed [OW-1:0] mag, ang_next, angle_q;
  logic                 dg_next, degen_q;
  always_comb begin
    za = zc + ZW'(RND_Q30);
    zq = za >>> RND_SH;
    if (zq[ZW-1]) begin
      mag = '0;
    end else if (zq > ZW'(PI_Q13)) begin
      mag = OW'(PI_Q13);
    end else begin
      mag = OW'(zq);
    end
    dg_next = 1'b0;
    if (tagc.yzero && tagc.xzero) begin
      ang_next = '0;
      dg_next  = 1'b1;
    end else if (tagc.yzero) begin
      ang_next = tagc.xneg ? OW'(PI_Q13) : '0;
    end else begin
      ang_next = tagc.vneg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_q <= ang_next;
      degen_q <= dg_next;
    end
  end

  assign res.valid      = vld[LAT-1];
  assign res.angle      = angle_q;
  assign res.degenerate = degen_q;

endmodule

@@ rtl/dap_checker.sv @@
// Port-level checks of the dihedral angle core, bound to the top level.
module dap_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 pts_valid,
  input logic                 pts_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [dap_pkg::OW-1:0] angle,
  input logic                 degenerate
);
  import dap_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(angle) && $stable(degenerate))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && degenerate |-> angle == '0)
    else $error("degenerate transaction with nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($signed(angle) <= signed'(OW'(PI_Q13))) &&
                  ($signed(angle) >= -signed'(OW'(PI_Q13))))
    else $error("angle outside -pi..pi");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid || res_ready |-> pts_ready)
    else $error("input stalled with output free");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !pts_ready)
    else $error("input taken while output held");

endmodule

bind dihedral_angle_four_points_core dap_checker u_dap_checker (
  .clk        (clk),
  .rst        (rst),
  .pts_valid  (pts.valid),
  .pts_ready  (pts.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .angle      (res.angle),
  .degenerate (res.degenerate)
);
